@@ src/ptfq_pkg.sv @@
`timescale 1ns / 1ps
package ptfq_pkg;

  // Field widths of one item
  localparam int PRIO_W    = 2;
  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int ST_W      = 3;
  localparam int MAX_BYTES = 8;

  // Result status codes
  localparam logic [ST_W-1:0] ST_QUEUED         = 3'd0;
  localparam logic [ST_W-1:0] ST_QUEUED_CLEARED = 3'd1;
  localparam logic [ST_W-1:0] ST_REJECTED       = 3'd2;
  localparam logic [ST_W-1:0] ST_SENT           = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY          = 3'd4;

  // Command kinds handed from the front to the back
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] CMD_ENQ    = 2'd0;
  localparam logic [KIND_W-1:0] CMD_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] CMD_SEND   = 2'd2;

  // Frame as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } frame_t;

  // Classified command
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PRIO_W-1:0] level;
    frame_t            frame;
  } cmd_t;

endpackage

@@ src/ptfq_front.sv @@
`timescale 1ns / 1ps
module ptfq_front import ptfq_pkg::*; #(
  parameter int LEVELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [ID_W-1:0]   in_frame_id,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [DATA_W-1:0] in_payload,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  localparam int QDEPTH = 2;

  cmd_t             cls;
  logic [DATA_W-1:0] kept;
  cmd_t             q_r [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;

  // Zero bytes beyond the frame length
  always_comb begin
    for (int b = 0; b < MAX_BYTES; b++) begin
      kept[b*8 +: 8] = (LEN_W'(b) < in_length) ? in_payload[b*8 +: 8] : 8'h00;
    end
  end

  // Classify the incoming item
  always_comb begin
    cls            = '0;
    cls.frame.id   = in_frame_id;
    cls.frame.len  = in_length;
    cls.frame.data = kept;
    if (int'(in_priority_req) >= LEVELS) begin
      cls.level = PRIO_W'(LEVELS - 1);
    end else begin
      cls.level = in_priority_req;
    end
    if (in_op) begin
      cls.kind = CMD_SEND;
    end else if (in_length > LEN_W'(MAX_BYTES)) begin
      cls.kind = CMD_REJECT;
    end else begin
      cls.kind = CMD_ENQ;
    end
  end

  assign in_stall  = (cnt_r == 2'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Advance the queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ src/ptfq_back.sv @@
`timescale 1ns / 1ps
module ptfq_back import ptfq_pkg::*; #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_LIMIT = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [ID_W-1:0]   out_id,
  output logic [LEN_W-1:0]  out_length,
  output logic [DATA_W-1:0] out_payload
);

  localparam int SLOTS = QUEUE_LIMIT + 1;
  localparam int OFFW  = $clog2(SLOTS);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW    = LVL_W + OFFW;
  localparam int DEPTH = LEVELS << OFFW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [OFFW-1:0]   head_r [LEVELS];
  logic [OFFW-1:0]   head_nxt [LEVELS];
  logic [FW-1:0]     fill_r [LEVELS];
  logic [FW-1:0]     fill_nxt [LEVELS];

  frame_t            mem [DEPTH];
  frame_t            mem_rd_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  frame_t            out_frame_r, out_frame_nxt;
  logic              load;
  logic              out_free;

  logic [LVL_W-1:0]  enq_lvl;
  logic              full;
  logic [OFFW-1:0]   base;
  logic [OFFW:0]     sum, wrapped;
  logic [OFFW-1:0]   slot_off;
  logic              found;
  logic [LVL_W-1:0]  sel;

  assign out_free = !out_valid_r || !out_stall;

  // Slot for an enqueue: head plus fill (head alone when the level is full), wrapped once
  always_comb begin
    enq_lvl  = LVL_W'(cmd.level);
    full     = fill_r[enq_lvl] > FW'(QUEUE_LIMIT);
    base     = full ? '0 : fill_r[enq_lvl][OFFW-1:0];
    sum      = {1'b0, head_r[enq_lvl]} + {1'b0, base};
    wrapped  = sum - (OFFW+1)'(SLOTS);
    slot_off = (sum >= (OFFW+1)'(SLOTS)) ? wrapped[OFFW-1:0] : sum[OFFW-1:0];
  end

  // Pick the most urgent non-empty level
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && fill_r[i] != '0) begin
        found = 1'b1;
        sel   = LVL_W'(i);
      end
    end
  end

  // Sequence one command
  always_comb begin
    state_nxt      = state_r;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = {enq_lvl, slot_off};
    load           = 1'b0;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    for (int i = 0; i < LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      fill_nxt[i] = fill_r[i];
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_ENQ: begin
              mem_we            = 1'b1;
              fill_nxt[enq_lvl] = full ? FW'(1) : fill_r[enq_lvl] + FW'(1);
              load              = 1'b1;
              out_status_nxt    = full ? ST_QUEUED_CLEARED : ST_QUEUED;
              out_frame_nxt     = '0;
            end
            CMD_SEND: begin
              if (found) begin
                mem_re        = 1'b1;
                mem_addr      = {sel, head_r[sel]};
                head_nxt[sel] = (head_r[sel] == OFFW'(SLOTS - 1)) ? '0
                                : head_r[sel] + OFFW'(1);
                fill_nxt[sel] = fill_r[sel] - FW'(1);
                state_nxt     = S_READ;
              end else begin
                load           = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_frame_nxt  = '0;
              end
            end
            default: begin
              load           = 1'b1;
              out_status_nxt = ST_REJECTED;
              out_frame_nxt  = '0;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load           = 1'b1;
          out_status_nxt = ST_SENT;
          out_frame_nxt  = mem_rd_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  // Hold the result
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  // Slot memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd.frame;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_id      = out_frame_r.id;
  assign out_length  = out_frame_r.len;
  assign out_payload = out_frame_r.data;

endmodule

@@ src/priority_tx_frame_queues_unit.sv @@
`timescale 1ns / 1ps
// Strict-priority transmit queues for standard CAN frames. Each of LEVELS
// levels keeps a circular FIFO of QUEUE_LIMIT+1 frames in one shared slot
// memory; level 0 is the most urgent. An enqueue item (in_op 0) stores the
// frame with bytes past its length zeroed and reports queued, or queued after
// clearing when the level was full; a length over 8 is rejected and nothing
// is stored. A transmit item (in_op 1) pops the head of the most urgent
// non-empty level, or reports that nothing is waiting. Every item yields
// exactly one result. Items pass through a two-entry command queue to the
// executing back end, which completes an enqueue, reject or empty transmit
// in its idle state; a transmit that sends a frame issues a registered read
// of the slot memory and completes in its read state. An accepted item is
// registered in the command queue, then its result in the output register.
// The slot memory needs no clearing after reset.
module priority_tx_frame_queues_unit import ptfq_pkg::*; #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_LIMIT = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [ID_W-1:0]   in_frame_id,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [DATA_W-1:0] in_payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [ID_W-1:0]   out_id,
  output logic [LEN_W-1:0]  out_length,
  output logic [DATA_W-1:0] out_payload
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Accept and classify
  ptfq_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_priority_req (in_priority_req),
    .in_frame_id     (in_frame_id),
    .in_length       (in_length),
    .in_payload      (in_payload),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // Execute against the queues
  ptfq_back #(
    .LEVELS      (LEVELS),
    .QUEUE_LIMIT (QUEUE_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_id      (out_id),
    .out_length  (out_length),
    .out_payload (out_payload)
  );

endmodule

@@ bench/priority_tx_frame_queues_unit_tb.sv @@
`timescale 1ns / 1ps
module priority_tx_frame_queues_unit_tb;
  import ptfq_pkg::*;

  localparam int LEVELS       = 4;
  localparam int QUEUE_LIMIT  = 15;
  localparam int SLOTS        = QUEUE_LIMIT + 1;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DIRECTED_N   = 23;
  localparam int EXP_DEPTH    = 4096;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_TRANSMIT = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_MIXED, TRAFFIC_FLOOD} traffic_e;

  // One result as it leaves the block
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } tx_result_t;

  // One row of the directed stimulus table
  typedef struct packed {
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [7:0]        reps;
    logic              fixed;
    tx_result_t        res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [PRIO_W-1:0] in_priority_req;
  logic [ID_W-1:0]   in_frame_id;
  logic [LEN_W-1:0]  in_length;
  logic [DATA_W-1:0] in_payload;
  logic              out_valid;
  logic              out_stall;
  logic [ST_W-1:0]   out_status;
  logic [ID_W-1:0]   out_id;
  logic [LEN_W-1:0]  out_length;
  logic [DATA_W-1:0] out_payload;

  // Shadow copy of the queue state
  logic [ID_W-1:0]   shadow_id   [LEVELS][SLOTS];
  logic [LEN_W-1:0]  shadow_len  [LEVELS][SLOTS];
  logic [DATA_W-1:0] shadow_data [LEVELS][SLOTS];
  int                shadow_head [LEVELS];
  int                shadow_fill [LEVELS];

  // Expected results in acceptance order
  tx_result_t exp_fifo [EXP_DEPTH];
  int         exp_wr;
  int         exp_rd;
  stim_row_t  directed_tab[DIRECTED_N];

  int err_count;
  int items_sent;
  int results_seen;
  int status_seen[8];
  int backpressure_cycles;
  int cycle_count;
  int send_gap_pct;
  int rx_stall_pct;
  int holds_asked;
  int holds_granted;
  int hold_left;

  priority_tx_frame_queues_unit #(
    .LEVELS(LEVELS),
    .QUEUE_LIMIT(QUEUE_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_priority_req(in_priority_req),
    .in_frame_id(in_frame_id),
    .in_length(in_length),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_id(out_id),
    .out_length(out_length),
    .out_payload(out_payload)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Work out the result of one item and advance the shadow queues
  function automatic tx_result_t predict_tx_queue(logic op, logic [PRIO_W-1:0] prio,
                                                  logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                                  logic [DATA_W-1:0] data);
    tx_result_t r;
    int lv;
    int slot;
    bit found;
    logic [DATA_W-1:0] mask;
    r = '0;
    found = 1'b0;
    if (op == OP_ENQUEUE) begin
      if (len > MAX_BYTES) begin
        r.status = ST_REJECTED;
      end else begin
        lv = (int'(prio) >= LEVELS) ? LEVELS - 1 : int'(prio);
        r.status = ST_QUEUED;
        // empty a full level before appending
        if (shadow_fill[lv] > QUEUE_LIMIT) begin
          shadow_fill[lv] = 0;
          r.status = ST_QUEUED_CLEARED;
        end
        slot = (shadow_head[lv] + shadow_fill[lv]) % SLOTS;
        mask = (len >= MAX_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        shadow_id[lv][slot]   = id;
        shadow_len[lv][slot]  = len;
        shadow_data[lv][slot] = data & mask;
        shadow_fill[lv]       = shadow_fill[lv] + 1;
      end
    end else begin
      // pop the most urgent non-empty level
      for (lv = 0; lv < LEVELS; lv++) begin
        if (!found && shadow_fill[lv] != 0) begin
          found = 1'b1;
          slot = shadow_head[lv];
          r.status = ST_SENT;
          r.id     = shadow_id[lv][slot];
          r.len    = shadow_len[lv][slot];
          r.data   = shadow_data[lv][slot];
          shadow_head[lv] = (shadow_head[lv] + 1) % SLOTS;
          shadow_fill[lv] = shadow_fill[lv] - 1;
        end
      end
      if (!found) r.status = ST_EMPTY;
    end
    return r;
  endfunction

  task automatic set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 52;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        rx_stall_pct = 52;
      end
      default: begin
        send_gap_pct = 27;
        rx_stall_pct = 27;
      end
    endcase
  endtask

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic offer_item(logic op, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id,
                            logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                            bit fixed, tx_result_t fixed_res);
    tx_result_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_priority_req <= prio;
    in_frame_id     <= id;
    in_length       <= len;
    in_payload      <= data;
    do @(posedge clk); while (in_stall);
    predicted = predict_tx_queue(op, prio, id, len, data);
    exp_fifo[exp_wr % EXP_DEPTH] = fixed ? fixed_res : predicted;
    exp_wr = exp_wr + 1;
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      holds_granted <= holds_granted + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    tx_result_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && in_stall) backpressure_cycles <= backpressure_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      status_seen[out_status] <= status_seen[out_status] + 1;
      if (exp_wr == exp_rd) begin
        if (err_count < 10)
          $display("unexpected result: status %0d id %h len %0d data %h",
                   out_status, out_id, out_length, out_payload);
        err_count <= err_count + 1;
      end else begin
        exp_res = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd  = exp_rd + 1;
        if (out_status !== exp_res.status || out_id !== exp_res.id ||
            out_length !== exp_res.len || out_payload !== exp_res.data) begin
          if (err_count < 10)
            $display("mismatch: expected status %0d id %h len %0d data %h, got status %0d id %h len %0d data %h",
                     exp_res.status, exp_res.id, exp_res.len, exp_res.data,
                     out_status, out_id, out_length, out_payload);
          err_count <= err_count + 1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t  row;
    traffic_e   traffic;
    int         flood_lvl;
    int         enq_pct;
    logic              r_op;
    logic [PRIO_W-1:0] r_prio;
    logic [LEN_W-1:0]  r_len;

    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_ENQUEUE;
    in_priority_req = '0;
    in_frame_id     = '0;
    in_length       = '0;
    in_payload      = '0;
    out_stall       = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    results_seen    = 0;
    backpressure_cycles = 0;
    cycle_count     = 0;
    holds_asked     = 0;
    holds_granted   = 0;
    hold_left       = 0;
    exp_wr          = 0;
    exp_rd          = 0;
    traffic         = TRAFFIC_MIXED;
    flood_lvl       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_head[i]) begin
      shadow_head[i] = 0;
      shadow_fill[i] = 0;
    end
    set_idle_mode(IDLE_NONE);

    // op, level, id, length, data, repeat, fixed expectation, expected result
    directed_tab = '{
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b1,
        '{ST_EMPTY, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd0, 11'h123, 4'd9,  64'h0F0F_0F0F_0F0F_0F0F, 8'd1, 1'b1,
        '{ST_REJECTED, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd3, 11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
        '{ST_REJECTED, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd3, 11'h7FF, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
        '{ST_QUEUED, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd0, 11'h000, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
        '{ST_QUEUED, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd1, 11'h555, 4'd3,  64'h0123_4567_89AB_CDEF, 8'd1, 1'b0, '0},
      '{OP_ENQUEUE,  2'd2, 11'h2AA, 4'd7,  64'hA5A5_A5A5_A5A5_A5A5, 8'd1, 1'b0, '0},
      '{OP_ENQUEUE,  2'd1, 11'h000, 4'd8,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b1,
        '{ST_SENT, 11'h000, 4'd0, 64'h0}},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b1,
        '{ST_SENT, 11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}},
      // transmit ignores its frame fields
      '{OP_TRANSMIT, 2'd3, 11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
        '{ST_EMPTY, 11'h000, 4'd0, 64'h0}},
      // fill level 2 to capacity, then overflow it
      '{OP_ENQUEUE,  2'd2, 11'h100, 4'd8,  64'hFEDC_BA98_7654_3210, 8'd16, 1'b0, '0},
      '{OP_ENQUEUE,  2'd2, 11'h3FF, 4'd1,  64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
        '{ST_QUEUED_CLEARED, 11'h000, 4'd0, 64'h0}},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b1,
        '{ST_EMPTY, 11'h000, 4'd0, 64'h0}},
      '{OP_ENQUEUE,  2'd0, 11'h001, 4'd4,  64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b0, '0},
      '{OP_ENQUEUE,  2'd3, 11'h400, 4'd6,  64'h5A5A_5A5A_5A5A_5A5A, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b0, '0},
      '{OP_TRANSMIT, 2'd0, 11'h000, 4'd0,  64'h0, 8'd1, 1'b1,
        '{ST_EMPTY, 11'h000, 4'd0, 64'h0}}
    };

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    set_idle_mode(IDLE_BOTH);
    for (int r = 0; r < DIRECTED_N; r++) begin
      row = directed_tab[r];
      for (int k = 0; k < int'(row.reps); k++)
        offer_item(row.op, row.prio, row.id, row.len, row.data, row.fixed, row.res);
    end

    // Random traffic in bursts of different character
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) set_idle_mode(idle_mode_e'((n / 150) % 4));
      if (n % 40 == 0) begin
        traffic   = traffic_e'($urandom_range(0, 3));
        flood_lvl = $urandom_range(0, LEVELS - 1);
      end
      // long receiver hold-off while the sender keeps offering
      if (n == 20 || n == 620) holds_asked = holds_asked + 1;
      case (traffic)
        TRAFFIC_FILL:  enq_pct = 85;
        TRAFFIC_DRAIN: enq_pct = 20;
        TRAFFIC_FLOOD: enq_pct = 90;
        default:       enq_pct = 50;
      endcase
      r_op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_TRANSMIT;
      r_prio = (traffic == TRAFFIC_FLOOD) ? PRIO_W'(flood_lvl)
                                          : PRIO_W'($urandom_range(0, LEVELS - 1));
      r_len  = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(0, MAX_BYTES))
                                            : LEN_W'($urandom_range(MAX_BYTES + 1, 15));
      offer_item(r_op, r_prio, ID_W'($urandom_range(0, 2047)), r_len,
                 {$urandom, $urandom}, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d results; %0d cycles of input backpressure seen",
             items_sent, results_seen, backpressure_cycles);
    $display("Results: %0d queued, %0d queued after clearing, %0d rejected, %0d sent, %0d empty",
             status_seen[ST_QUEUED], status_seen[ST_QUEUED_CLEARED], status_seen[ST_REJECTED],
             status_seen[ST_SENT], status_seen[ST_EMPTY]);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
